// ===== design/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 code point decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int BITS_W = 7;

    typedef logic [2:0] t_kind;

    // Byte classes found by the front end.
    localparam t_kind KIND_ASCII = 3'd0;
    localparam t_kind KIND_CONT  = 3'd1;
    localparam t_kind KIND_LEAD2 = 3'd2;
    localparam t_kind KIND_LEAD3 = 3'd3;
    localparam t_kind KIND_LEAD4 = 3'd4;
    localparam t_kind KIND_BAD   = 3'd5;

    localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR       = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURROGATE_LOW    = 21'h00D800;
    localparam logic [CP_W-1:0] SURROGATE_HIGH   = 21'h00DFFF;

    // One classified byte: its class, its payload bits and the end flag.
    typedef struct packed {
        t_kind             kind;
        logic [BITS_W-1:0] bits;
        logic              eot;
    } t_item;

endpackage

// ===== design/utf8_code_point_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_code_point_decoder
// Streaming UTF-8 decoder with validation, one byte in per item.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and sustains one item per cycle on both
// sides while the output is not stalled by tready; the sequence state is
// updated once per accepted byte. A byte passes a classify register, a
// two-entry queue and the output register before its code point appears.
// ASCII bytes and closing continuation bytes give a result,
// other bytes of a sequence give none. Invalid bytes, overlong forms,
// surrogates, values above 0x10FFFF and sequences cut short by tlast give
// 0xFFFD with tuser set. Every input byte with tlast gives exactly one
// result with tlast, and the decoder is idle afterwards.
module utf8_code_point_decoder
    import u8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        o_m_axis_tuser,   // [0] replaced
    output logic        o_m_axis_tlast
);

    logic            w_f_valid;
    logic            w_f_ready;
    t_item           w_f_item;
    logic            w_q_valid;
    logic            w_q_ready;
    t_item           w_q_item;
    logic [CP_W-1:0] w_cp;

    u8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_eot   (i_s_axis_tlast),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_item  (w_f_item)
    );

    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    u8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .o_ready      (w_q_ready),
        .i_item       (w_q_item),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_code_point (w_cp),
        .o_replaced   (o_m_axis_tuser),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, w_cp};

    // A replaced result always carries the replacement character.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (w_cp == REPLACEMENT_CHAR))
        else $error("replaced result without replacement character");

    // A result that is not replaced is a Unicode scalar value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
            ((w_cp <= MAX_SCALAR) && ((w_cp < SURROGATE_LOW) || (w_cp > SURROGATE_HIGH))))
        else $error("accepted result is not a scalar value");

    // A new result only comes from an item that waited in the queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_q_valid))
        else $error("result appeared without a queued item");

endmodule

// ===== design/u8d_front.sv =====
// ----------------------------------------------------------------------------
// u8d_front
// Accepts raw bytes, classifies them and holds one classified item.
// ----------------------------------------------------------------------------
module u8d_front
    import u8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_eot,
    output logic              o_valid,
    input  logic              i_ready,
    output t_item             o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.eot = i_eot;
        if (!i_byte[7]) begin
            n_item.kind = KIND_ASCII;
            n_item.bits = i_byte[6:0];
        end else if (!i_byte[6]) begin
            n_item.kind = KIND_CONT;
            n_item.bits = {1'b0, i_byte[5:0]};
        end else if (!i_byte[5]) begin
            n_item.kind = KIND_LEAD2;
            n_item.bits = {2'b00, i_byte[4:0]};
        end else if (!i_byte[4]) begin
            n_item.kind = KIND_LEAD3;
            n_item.bits = {3'b000, i_byte[3:0]};
        end else if (!i_byte[3]) begin
            n_item.kind = KIND_LEAD4;
            n_item.bits = {4'b0000, i_byte[2:0]};
        end else begin
            n_item.kind = KIND_BAD;
            n_item.bits = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== design/u8d_queue.sv =====
// ----------------------------------------------------------------------------
// u8d_queue
// Two-entry queue of classified items between front end and back end.
// ----------------------------------------------------------------------------
module u8d_queue
    import u8d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== design/u8d_back.sv =====
// ----------------------------------------------------------------------------
// u8d_back
// Sequence state, code point assembly, validation and the output register.
// ----------------------------------------------------------------------------
module u8d_back
    import u8d_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_item           i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [CP_W-1:0] o_code_point,
    output logic            o_replaced,
    output logic            o_last
);

    logic [1:0]      r_pend;
    logic [CP_W-1:0] r_acc;
    logic [2:0]      r_len;
    logic [1:0]      n_pend;
    logic [CP_W-1:0] n_acc;
    logic [2:0]      n_len;

    logic            r_out_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_rep;
    logic            r_last;
    logic            n_emit;
    logic [CP_W-1:0] n_cp;
    logic            n_rep;

    logic            w_fire;
    logic [CP_W-1:0] w_shifted;
    logic            w_scalar_ok;
    logic [CP_W-1:0] w_lo;
    logic [CP_W-1:0] w_hi;

    assign o_ready      = !r_out_valid || i_ready;
    assign w_fire       = i_valid && o_ready;
    assign o_valid      = r_out_valid;
    assign o_code_point = r_cp;
    assign o_replaced   = r_rep;
    assign o_last       = r_last;

    assign w_shifted = {r_acc[CP_W-7:0], i_item.bits[5:0]};

    // Bounds of the value for the length of the open sequence.
    always_comb begin
        if (r_len == 3'd2) begin
            w_lo = 21'h000080;
            w_hi = 21'h0007FF;
        end else if (r_len == 3'd3) begin
            w_lo = 21'h000800;
            w_hi = 21'h00FFFF;
        end else begin
            w_lo = 21'h010000;
            w_hi = MAX_SCALAR;
        end
    end

    assign w_scalar_ok = (w_shifted >= w_lo) && (w_shifted <= w_hi) &&
                         !((w_shifted >= SURROGATE_LOW) && (w_shifted <= SURROGATE_HIGH));

    always_comb begin
        n_pend = r_pend;
        n_acc  = r_acc;
        n_len  = r_len;
        n_emit = 1'b0;
        n_cp   = REPLACEMENT_CHAR;
        n_rep  = 1'b1;
        if (r_pend == 2'd0) begin
            unique case (i_item.kind) inside
                KIND_ASCII: begin
                    n_emit = 1'b1;
                    n_cp   = {14'd0, i_item.bits};
                    n_rep  = 1'b0;
                end
                KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
                    n_acc = {14'd0, i_item.bits};
                    if (i_item.kind == KIND_LEAD2) begin
                        n_pend = 2'd1;
                        n_len  = 3'd2;
                    end else if (i_item.kind == KIND_LEAD3) begin
                        n_pend = 2'd2;
                        n_len  = 3'd3;
                    end else begin
                        n_pend = 2'd3;
                        n_len  = 3'd4;
                    end
                    // A lead byte that ends the text closes a cut-short sequence.
                    if (i_item.eot) begin
                        n_emit = 1'b1;
                        n_pend = 2'd0;
                        n_acc  = '0;
                        n_len  = 3'd0;
                    end
                end
                default: begin
                    n_emit = 1'b1;
                end
            endcase
        end else if (i_item.kind != KIND_CONT) begin
            n_emit = 1'b1;
            n_pend = 2'd0;
            n_acc  = '0;
            n_len  = 3'd0;
        end else if (r_pend == 2'd1) begin
            n_emit = 1'b1;
            n_pend = 2'd0;
            n_acc  = '0;
            n_len  = 3'd0;
            if (w_scalar_ok) begin
                n_cp  = w_shifted;
                n_rep = 1'b0;
            end
        end else if (i_item.eot) begin
            n_emit = 1'b1;
            n_pend = 2'd0;
            n_acc  = '0;
            n_len  = 3'd0;
        end else begin
            n_pend = r_pend - 2'd1;
            n_acc  = w_shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 2'd0;
            r_acc       <= '0;
            r_len       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_pend <= n_pend;
                r_acc  <= n_acc;
                r_len  <= n_len;
            end
            if (o_ready) begin
                r_out_valid <= w_fire && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_emit) begin
            r_cp   <= n_cp;
            r_rep  <= n_rep;
            r_last <= i_item.eot;
        end
    end

endmodule
